[rtl/ppsd_pkg.sv]
package ppsd_pkg;

	// Field and register widths
	localparam int MAG_W      = 16;
	localparam int TIME_W     = 32;
	localparam int COUNT_W    = 24;
	localparam int DIST_W     = 32;
	localparam int MUL_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int LEN_W      = 8;
	localparam int ENERGY_W   = 10;

	localparam int FILTER_DEPTH_DEF = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Register reset values
	localparam logic [15:0]         PEAK_LEVEL_RST  = 16'd5325;
	localparam logic [15:0]         SLOPE_LEVEL_RST = 16'd205;
	localparam logic [15:0]         MIN_GAP_RST     = 16'd200;
	localparam logic [LEN_W-1:0]    STEP_LENGTH_RST = 8'd75;
	localparam logic [ENERGY_W-1:0] ENERGY_RST      = 10'd40;

	// floor(n / 1000) = floor(floor(n / 8) * CAL_RECIP / 2^38) for n < 2^34
	localparam int               CAL_PRE   = 3;
	localparam int               CAL_SHIFT = 38;
	localparam logic [MUL_W-1:0] CAL_RECIP = 32'd2199023256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEAK_LEVEL  = 3'd0,
		REG_SLOPE_LEVEL = 3'd1,
		REG_MIN_GAP     = 3'd2,
		REG_STEP_LENGTH = 3'd3,
		REG_ENERGY      = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef struct packed {
		logic                     operation;
		logic                     sample_valid;
		logic signed [MAG_W-1:0]  accel_x;
		logic signed [MAG_W-1:0]  accel_y;
		logic signed [MAG_W-1:0]  accel_z;
		logic [TIME_W-1:0]        time_ms;
	} in_item_t;

	typedef struct packed {
		logic                     step_found;
		logic [COUNT_W-1:0]       step_total;
		logic [DIST_W-1:0]        distance_cm;
		logic [COUNT_W-1:0]       calories_kcal;
		logic [MAG_W-1:0]         filtered_magnitude;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Z,
		ST_SQ_START,
		ST_SQRT,
		ST_HIST,
		ST_AVG,
		ST_DET,
		ST_DIST,
		ST_CAL_MUL,
		ST_CAL_DIV,
		ST_RESULT
	} ppsd_state_t;

endpackage

[rtl/ppsd_in_if.sv]
interface ppsd_in_if;
	import ppsd_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/ppsd_out_if.sv]
interface ppsd_out_if;
	import ppsd_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/pedometer_peak_step_detector_core.sv]
// Channel  | Dir | Handshake     | Payload
// ---------+-----+---------------+-----------------------------------------------
// in_ch    | in  | valid / ready | operation, sample_valid, accel_x/y/z, time_ms
// out_ch   | out | valid / ready | step_found, step_total, distance_cm,
//          |     |               | calories_kcal, filtered_magnitude
// cfg      | in  | cfg_we        | cfg_index, cfg_data (no read-back)
//
// A valid sample passes squares, bit-serial square root, history, average,
// detector, distance and calories; its arithmetic runs on the shared
// 32x32 multiplier used once per cycle for squares, average, distance, calories.
// A clear or an invalid sample skips to the multiplier for distance/calories.
// in_ch.ready is high only while idle, so a new transfer waits until the core
// is back in ST_IDLE. The result register lets the
// next item enter while out_ch stalls; a second finished item waits in ST_RESULT.
// Reset (arst_n low) clears history, detector state, count; resets registers.
module pedometer_peak_step_detector_core #(
	parameter int FILTER_DEPTH = ppsd_pkg::FILTER_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	ppsd_in_if.sink                          in_ch,
	ppsd_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [ppsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ppsd_pkg::*;

	// Moving average: sum / FILTER_DEPTH as a multiply by a rounded-up
	// reciprocal, exact for every sum below 2^SUM_W.
	localparam int               DEPTH_LOG = $clog2(FILTER_DEPTH);
	localparam int               SUM_W     = MAG_W + DEPTH_LOG;
	localparam int               AVG_SHIFT = SUM_W + DEPTH_LOG;
	localparam logic [MUL_W-1:0] AVG_RECIP = MUL_W'(((64'd1 << AVG_SHIFT)
		+ 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));

	ppsd_state_t state_q, state_d;

	// configuration registers
	logic [15:0]         peak_level_q;
	logic [15:0]         slope_level_q;
	logic [15:0]         min_gap_q;
	logic [LEN_W-1:0]    step_length_q;
	logic [ENERGY_W-1:0] energy_q;

	// item and datapath
	in_item_t            in_q;
	logic [MAG_W-1:0]    abs_x, abs_y, abs_z;
	logic [2*MAG_W-1:0]  acc_q;
	logic                mul_en;
	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [2*MUL_W-1:0]  mul_p;
	logic                sq_start, sq_done;
	logic [MAG_W-1:0]    sq_root;
	logic                hist_wr;
	logic [SUM_W-1:0]    hist_sum;
	logic                gap_ok_q;
	logic [DIST_W-1:0]   dist_q;

	// detector state
	logic [MAG_W-1:0]    prev_q;
	logic                armed_q;
	logic [MAG_W-1:0]    peak_q;
	logic [TIME_W-1:0]   last_q;
	logic [COUNT_W-1:0]  count_q;
	logic                found_q;

	logic [MAG_W-1:0]    filt;
	logic                rise, fall;
	logic [COUNT_W+1:0]  cal_raw;
	logic [COUNT_W-1:0]  cal_sat;
	logic                out_load;
	logic                out_valid_q;
	out_item_t           out_q;

	function automatic logic [MAG_W-1:0] abs16(input logic [MAG_W-1:0] v);
		return v[MAG_W-1] ? (~v + 1'b1) : v;
	endfunction

	assign abs_x = abs16(in_q.accel_x);
	assign abs_y = abs16(in_q.accel_y);
	assign abs_z = abs16(in_q.accel_z);

	ppsd_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ppsd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_q + mul_p[2*MAG_W-1:0]),
		.root     (sq_root),
		.done     (sq_done)
	);

	ppsd_hist #(
		.DEPTH (FILTER_DEPTH),
		.SUM_W (SUM_W)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (hist_wr),
		.mag    (sq_root),
		.sum    (hist_sum)
	);

	// Average comes out of the multiplier the cycle after ST_AVG.
	assign filt = mul_p[AVG_SHIFT +: MAG_W];
	// rise: filt - prev > slope; fall: prev - filt > slope
	assign rise = {1'b0, filt} > ({1'b0, prev_q} + {1'b0, slope_level_q});
	assign fall = {1'b0, prev_q} > ({1'b0, filt} + {1'b0, slope_level_q});

	// floor(total * energy / 1000); only saturates when energy > 1000
	assign cal_raw = mul_p[CAL_SHIFT +: COUNT_W+2];
	assign cal_sat = (cal_raw > (COUNT_W+2)'(COUNT_MAX)) ? COUNT_MAX : cal_raw[COUNT_W-1:0];

	assign in_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: one multiplier use or one root step per cycle
	always_comb begin
		state_d  = state_q;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		sq_start = 1'b0;
		hist_wr  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.data.operation == OP_CLEAR || !in_ch.data.sample_valid) begin
						state_d = ST_DIST;
					end else begin
						state_d = ST_MUL_X;
					end
				end
			end
			ST_MUL_X: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(abs_x);
				mul_b   = MUL_W'(abs_x);
				state_d = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(abs_y);
				mul_b   = MUL_W'(abs_y);
				state_d = ST_MUL_Z;
			end
			ST_MUL_Z: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(abs_z);
				mul_b   = MUL_W'(abs_z);
				state_d = ST_SQ_START;
			end
			ST_SQ_START: begin
				sq_start = 1'b1;
				state_d  = ST_SQRT;
			end
			ST_SQRT: begin
				if (sq_done) begin
					state_d = ST_HIST;
				end
			end
			ST_HIST: begin
				hist_wr = 1'b1;
				state_d = ST_AVG;
			end
			ST_AVG: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(hist_sum);
				mul_b   = AVG_RECIP;
				state_d = ST_DET;
			end
			ST_DET: begin
				state_d = ST_DIST;
			end
			ST_DIST: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(count_q);
				mul_b   = MUL_W'(step_length_q);
				state_d = ST_CAL_MUL;
			end
			ST_CAL_MUL: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(count_q);
				mul_b   = MUL_W'(energy_q);
				state_d = ST_CAL_DIV;
			end
			ST_CAL_DIV: begin
				// divide by 8 by shift, then by 125 by reciprocal
				mul_en  = 1'b1;
				mul_a   = MUL_W'(mul_p[CAL_PRE +: MUL_W-1]);
				mul_b   = CAL_RECIP;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_level_q  <= PEAK_LEVEL_RST;
			slope_level_q <= SLOPE_LEVEL_RST;
			min_gap_q     <= MIN_GAP_RST;
			step_length_q <= STEP_LENGTH_RST;
			energy_q      <= ENERGY_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PEAK_LEVEL:  peak_level_q  <= cfg_data;
				REG_SLOPE_LEVEL: slope_level_q <= cfg_data;
				REG_MIN_GAP:     min_gap_q     <= cfg_data;
				REG_STEP_LENGTH: step_length_q <= cfg_data[LEN_W-1:0];
				REG_ENERGY:      energy_q      <= cfg_data[ENERGY_W-1:0];
				default: ;
			endcase
		end
	end

	// detector and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			armed_q <= 1'b0;
			peak_q  <= '0;
			last_q  <= '0;
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && in_ch.valid) begin
				found_q <= 1'b0;
				if (in_ch.data.operation == OP_CLEAR) begin
					count_q <= '0;
				end
			end
			if (state_q == ST_DET) begin
				prev_q <= filt;
				if (gap_ok_q) begin
					if (rise && filt > peak_level_q) begin
						armed_q <= 1'b1;
						if (filt > peak_q) begin
							peak_q <= filt;
						end
					end else if (armed_q && fall && peak_q > peak_level_q) begin
						armed_q <= 1'b0;
						peak_q  <= '0;
						last_q  <= in_q.time_ms;
						found_q <= 1'b1;
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			in_q <= in_ch.data;
		end
		if (state_q == ST_MUL_Y) begin
			acc_q <= mul_p[2*MAG_W-1:0];
		end else if (state_q == ST_MUL_Z) begin
			acc_q <= acc_q + mul_p[2*MAG_W-1:0];
		end
		if (state_q == ST_HIST) begin
			// wrapping elapsed time since the last counted step
			gap_ok_q <= (in_q.time_ms - last_q) >= TIME_W'(min_gap_q);
		end
		if (state_q == ST_CAL_MUL) begin
			dist_q <= mul_p[DIST_W-1:0];
		end
		if (out_load) begin
			out_q.step_found         <= found_q;
			out_q.step_total         <= count_q;
			out_q.distance_cm        <= dist_q;
			out_q.calories_kcal      <= cal_sat;
			out_q.filtered_magnitude <= prev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
endmodule

[rtl/ppsd_mul.sv]
module ppsd_mul (
	input  logic                           clk,
	input  logic                           en,
	input  logic [ppsd_pkg::MUL_W-1:0]     a,
	input  logic [ppsd_pkg::MUL_W-1:0]     b,
	output logic [2*ppsd_pkg::MUL_W-1:0]   p
);
	import ppsd_pkg::*;

	logic [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;
endmodule

[rtl/ppsd_isqrt.sv]
module ppsd_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [2*ppsd_pkg::MAG_W-1:0]   radicand,
	output logic [ppsd_pkg::MAG_W-1:0]     root,
	output logic                           done
);
	import ppsd_pkg::*;

	localparam int CNT_W = $clog2(MAG_W);
	localparam int REM_W = MAG_W + 2;

	logic [2*MAG_W-1:0] rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [MAG_W-1:0]   root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;

	logic [REM_W+1:0]   rem_sh;
	logic [REM_W+1:0]   trial;
	logic [REM_W+1:0]   diff;
	logic               take;

	// one result bit per cycle, two radicand bits shifted in
	assign rem_sh = {rem_q, rad_q[2*MAG_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign take   = (rem_sh >= trial);
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*MAG_W-3:0], 2'b00};
			rem_q  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[MAG_W-2:0], take};
		end
	end

	assign done = busy_q && (cnt_q == CNT_W'(MAG_W - 1));
	assign root = root_q;
endmodule

[rtl/ppsd_hist.sv]
module ppsd_hist #(
	parameter int DEPTH = ppsd_pkg::FILTER_DEPTH_DEF,
	parameter int SUM_W = ppsd_pkg::MAG_W + $clog2(ppsd_pkg::FILTER_DEPTH_DEF)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [ppsd_pkg::MAG_W-1:0] mag,
	output logic [SUM_W-1:0]           sum
);
	import ppsd_pkg::*;

	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [MAG_W-1:0]  hist_q [DEPTH];
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  sum_q;
	logic [MAG_W-1:0]  old_mag;

	assign old_mag = hist_q[slot_q];

	// running sum: drop the overwritten entry, add the new one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			slot_q <= '0;
			sum_q  <= '0;
		end else if (wr) begin
			hist_q[slot_q] <= mag;
			slot_q         <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
			sum_q          <= sum_q - SUM_W'(old_mag) + SUM_W'(mag);
		end
	end

	assign sum = sum_q;
endmodule

[rtl/ppsd_checker.sv]
module ppsd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input ppsd_pkg::out_item_t out_data
);
	import ppsd_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one item at a time: ready falls right after an input transfer
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a counted step leaves a nonzero total
	a_found_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.step_found |-> out_data.step_total != '0)
		else $error("step found with zero total");

	// zero steps give zero distance and calories
	a_zero_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.step_total == '0 |->
			out_data.distance_cm == '0 && out_data.calories_kcal == '0)
		else $error("distance or calories without steps");
endmodule

bind pedometer_peak_step_detector_core ppsd_checker u_ppsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

[tb/tb_pedometer_peak_step_detector_core.sv]
`timescale 1ns / 100ps

module tb_pedometer_peak_step_detector_core;
	import ppsd_pkg::*;

	typedef longint unsigned u64_t;

	localparam int AVG_DEPTH  = FILTER_DEPTH_DEF;
	localparam int CYCLE_CAP  = 1000000;
	// Long enough to cover the sample path through the core plus slack.
	localparam int SETTLE     = 40;
	localparam int LONG_HOLD  = 300;
	// First index past the register file; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

	// ------------------------------------------------------------------
	// Clock, reset, DUT
	// ------------------------------------------------------------------
	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ppsd_in_if  in_ch ();
	ppsd_out_if out_ch ();

	initial clk = 1'b0;
	always #5 clk = ~clk;

	pedometer_peak_step_detector_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor copy of the registers and the detector state
	// ------------------------------------------------------------------
	logic [15:0]         cfg_peak;
	logic [15:0]         cfg_slope;
	logic [15:0]         cfg_gap;
	logic [LEN_W-1:0]    cfg_len;
	logic [ENERGY_W-1:0] cfg_energy;

	logic [MAG_W-1:0]   hist_mag [AVG_DEPTH];
	int unsigned        hist_slot;
	logic [MAG_W-1:0]   prev_avg;
	logic               armed;
	logic [MAG_W-1:0]   peak_avg;
	logic [TIME_W-1:0]  step_stamp_ms;
	logic [COUNT_W-1:0] steps;

	// Pending stimulus and results still owed by the DUT
	in_item_t  sample_queue [$];
	out_item_t exp_results [$];

	// Bookkeeping
	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  steps_seen;
	int  settings_used;
	int  cycles;
	bit  in_taken;
	bit  calm;           // no idling on either side while set
	bit  long_hold_req;  // asks the receiver for one long hold-off
	int  send_gap;
	int  rx_gap;
	int  hold_cnt;

	// Walking-pattern generator state
	logic [31:0] t_now;
	int          walk_pos;
	int          walk_len;
	int          hi_amp;
	int          lo_amp;

	out_item_t want;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// Bit-at-a-time floor square root.
	function automatic logic [15:0] floor_sqrt(input u64_t n);
		u64_t root;
		u64_t bitv;
		root = 0;
		bitv = u64_t'(1) << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n    -= root + bitv;
				root  = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return 16'(root);
	endfunction

	// Advances the state by one transfer and returns the result it owes.
	function automatic out_item_t predict_step(input in_item_t it);
		out_item_t   r;
		longint      xs;
		longint      ys;
		longint      zs;
		u64_t        sq;
		u64_t        sum;
		u64_t        cal;
		logic [15:0] avg;
		logic [31:0] elapsed;
		longint      delta;
		logic        found;
		int          i;

		found = 1'b0;
		if (it.operation == OP_CLEAR) begin
			// clear hits the total only, sample_valid does not matter
			steps = '0;
		end else if (it.sample_valid) begin
			xs  = longint'($signed(it.accel_x));
			ys  = longint'($signed(it.accel_y));
			zs  = longint'($signed(it.accel_z));
			sq  = u64_t'(xs * xs) + u64_t'(ys * ys) + u64_t'(zs * zs);
			hist_mag[hist_slot] = floor_sqrt(sq);
			hist_slot = (hist_slot + 1) % AVG_DEPTH;
			sum = 0;
			for (i = 0; i < AVG_DEPTH; i++)
				sum += hist_mag[i];
			avg = 16'(sum / AVG_DEPTH);

			// wrapping 32-bit distance from the last counted step
			elapsed = it.time_ms - step_stamp_ms;
			if (elapsed >= cfg_gap) begin
				delta = longint'(avg) - longint'(prev_avg);
				if (delta > longint'(cfg_slope) && avg > cfg_peak) begin
					armed = 1'b1;
					if (avg > peak_avg)
						peak_avg = avg;
				end else if (armed && delta < -longint'(cfg_slope) &&
					     peak_avg > cfg_peak) begin
					armed         = 1'b0;
					peak_avg      = '0;
					step_stamp_ms = it.time_ms;
					found         = 1'b1;
					if (steps != COUNT_MAX)
						steps++;
				end
			end
			prev_avg = avg;
		end
		// invalid samples fall through: nothing moves

		cal = (u64_t'(steps) * cfg_energy) / 1000;
		if (cal > u64_t'(COUNT_MAX))
			cal = u64_t'(COUNT_MAX);

		r.step_found         = found;
		r.step_total         = steps;
		r.distance_cm        = 32'(u64_t'(steps) * cfg_len);
		r.calories_kcal      = 24'(cal);
		r.filtered_magnitude = prev_avg;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Mostly short gaps, a few long ones; zero while calm.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	function automatic in_item_t mk_item(input logic op, input logic vld, input int x,
					     input int y, input int z, input logic [31:0] t);
		in_item_t it;
		it.operation    = op;
		it.sample_valid = vld;
		it.accel_x      = 16'(x);
		it.accel_y      = 16'(y);
		it.accel_z      = 16'(z);
		it.time_ms      = t;
		return it;
	endfunction

	task automatic push_sample(input int x, input int y, input int z, input logic [31:0] t);
		sample_queue.push_back(mk_item(OP_SAMPLE, 1'b1, x, y, z, t));
	endtask

	// Everything but op and valid drawn at random.
	task automatic push_scrambled(input logic op, input logic vld);
		sample_queue.push_back(mk_item(op, vld, $urandom, $urandom, $urandom, $urandom));
	endtask

	// Walking-like traffic: bursts above the peak level followed by quiet
	// stretches, with some clears, dropped reads, raw noise and time jumps.
	task automatic push_walk(input int n);
		int k;
		int r;
		int m;
		int d;
		int ax [3];
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				push_scrambled(OP_CLEAR, 1'($urandom));
			end else if (r < 7) begin
				push_scrambled(OP_SAMPLE, 1'b0);
			end else if (r < 9) begin
				push_scrambled(OP_SAMPLE, 1'b1);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5)
					t_now += $urandom_range(0, 20);
				else if (r < 7)
					t_now += $urandom;
				else
					t_now += $urandom_range(30, 70);

				m = (walk_pos < walk_len / 2) ? hi_amp : lo_amp;
				m = m + int'($urandom_range(0, 400)) - 200;
				if (m < 0)
					m = 0;
				if (m > 32767)
					m = 32767;
				d = $urandom_range(0, 2);
				ax[0] = int'($urandom_range(0, 1000)) - 500;
				ax[1] = int'($urandom_range(0, 1000)) - 500;
				ax[2] = int'($urandom_range(0, 1000)) - 500;
				ax[d] = $urandom_range(0, 1) ? m : -m;
				push_sample(ax[0], ax[1], ax[2], t_now);

				walk_pos++;
				if (walk_pos >= walk_len) begin
					walk_pos = 0;
					walk_len = $urandom_range(4, 14);
					hi_amp   = $urandom_range(5000, 20000);
					lo_amp   = $urandom_range(0, 4500);
				end
			end
		end
	endtask

	// Register write; the predictor copy masks to width and drops bad indexes.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_PEAK_LEVEL:  cfg_peak   = val;
			REG_SLOPE_LEVEL: cfg_slope  = val;
			REG_MIN_GAP:     cfg_gap    = val;
			REG_STEP_LENGTH: cfg_len    = val[LEN_W-1:0];
			REG_ENERGY:      cfg_energy = val[ENERGY_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [15:0] peak, input logic [15:0] slope,
				     input logic [15:0] gap, input logic [15:0] len,
				     input logic [15:0] energy);
		write_reg(REG_PEAK_LEVEL, peak);
		write_reg(REG_SLOPE_LEVEL, slope);
		write_reg(REG_MIN_GAP, gap);
		write_reg(REG_STEP_LENGTH, len);
		write_reg(REG_ENERGY, energy);
		settings_used++;
	endtask

	// Wait until everything sent has come back, then let the core settle.
	task automatic drain();
		while (sample_queue.size() != 0 || exp_results.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic check_field(input string name, input u64_t e, input u64_t a);
		if (e != a) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, e, a);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Input driver: offers at the falling edge, holds until the transfer.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			exp_results.push_back(predict_step(in_ch.data));
			items_sent++;
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && !in_taken) begin
				// item still on offer, keep it steady
			end else if (send_gap > 0) begin
				send_gap--;
				in_ch.valid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				in_ch.data  <= sample_queue.pop_front();
				in_ch.valid <= 1'b1;
				send_gap     = pick_gap();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	// ------------------------------------------------------------------
	// Result side: random back-pressure plus one long hold-off on request.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ch.ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_cnt      = LONG_HOLD - 1;
			out_ch.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ch.ready <= 1'b0;
		end else begin
			rx_gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
			if (rx_gap > 0) begin
				rx_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: every result transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (exp_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got total %0d",
					 $time, out_ch.data.step_total);
				mismatches++;
			end else begin
				want = exp_results.pop_front();
				check_field("step_found", want.step_found, out_ch.data.step_found);
				check_field("step_total", want.step_total, out_ch.data.step_total);
				check_field("distance_cm", want.distance_cm, out_ch.data.distance_cm);
				check_field("calories_kcal", want.calories_kcal,
					    out_ch.data.calories_kcal);
				check_field("filtered_magnitude", want.filtered_magnitude,
					    out_ch.data.filtered_magnitude);
				results_seen++;
				if (want.step_found)
					steps_seen++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("pedometer_peak_step_detector_core: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int k;
		int p;

		// every DUT input known from time zero
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		arst_n       = 1'b0;

		cfg_peak       = PEAK_LEVEL_RST;
		cfg_slope      = SLOPE_LEVEL_RST;
		cfg_gap        = MIN_GAP_RST;
		cfg_len        = STEP_LENGTH_RST;
		cfg_energy     = ENERGY_RST;
		for (k = 0; k < AVG_DEPTH; k++)
			hist_mag[k] = '0;
		hist_slot      = 0;
		prev_avg       = '0;
		armed          = 1'b0;
		peak_avg       = '0;
		step_stamp_ms  = '0;
		steps          = '0;

		mismatches    = 0;
		items_sent    = 0;
		results_seen  = 0;
		steps_seen    = 0;
		settings_used = 1;
		cycles        = 0;
		in_taken      = 1'b0;
		calm          = 1'b0;
		long_hold_req = 1'b0;
		send_gap      = 0;
		rx_gap        = 0;
		hold_cnt      = 0;
		t_now         = '0;
		walk_pos      = 0;
		walk_len      = 8;
		hi_amp        = 12000;
		lo_amp        = 2000;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset register values.
		// zero vector while still inside the gap from time zero
		push_sample(0, 0, 0, 32'd0);
		// largest magnitudes the axes allow
		push_sample(-32768, -32768, -32768, 32'd1000);
		push_sample(32767, 32767, 32767, 32'd1050);
		push_sample(-32768, 32767, 0, 32'd1100);
		// dropped read, then a clear that carries valid low
		push_scrambled(OP_SAMPLE, 1'b0);
		push_scrambled(OP_CLEAR, 1'b0);
		for (k = 0; k < 4; k++)
			push_sample(0, 0, 0, 32'd1150 + 50 * k);
		// one clean step: 4 g burst then rest
		for (k = 0; k < 3; k++)
			push_sample(0, 0, 16384, 32'd2000 + 50 * k);
		for (k = 0; k < 3; k++)
			push_sample(0, 0, 0, 32'd2150 + 50 * k);
		// clear with valid high
		push_scrambled(OP_CLEAR, 1'b1);
		// a step across the 32-bit time wrap
		for (k = 0; k < 3; k++)
			push_sample(16384, 0, 0, 32'hFFFF_FF00 + 50 * k);
		for (k = 0; k < 3; k++)
			push_sample(0, 0, 0, 32'h0000_0020 + 50 * k);
		t_now = 32'h0000_0200;
		drain();

		// Reset values written back; receiver goes away for a long stretch
		// while the sender keeps offering, so the input backs up.
		apply_setting(PEAK_LEVEL_RST, SLOPE_LEVEL_RST, MIN_GAP_RST,
			      16'(STEP_LENGTH_RST), 16'(ENERGY_RST));
		long_hold_req = 1'b1;
		push_walk(150);
		drain();

		// Low extremes: every rise arms, every fall counts. No idling here.
		calm = 1'b1;
		apply_setting(16'd0, 16'd0, 16'd0, 16'd255, 16'd1000);
		push_walk(120);
		drain();
		calm = 1'b0;

		// High extremes: nothing can be detected; stray indexes ignored.
		apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
		for (k = REG_UNUSED_FIRST; k < (1 << CFG_IDX_W); k++)
			write_reg(CFG_IDX_W'(k), 16'($urandom));
		push_walk(80);
		drain();

		// Upper bits of the narrow registers must be masked off; the sender
		// also pauses mid-phase until everything has come back.
		apply_setting(16'd4500, 16'd100, 16'd150, 16'hFF4B, 16'hFFFF);
		push_walk(75);
		drain();
		push_walk(75);
		drain();

		// Random settings
		for (p = 0; p < 3; p++) begin
			apply_setting(($urandom_range(0, 3) == 0) ? 16'($urandom)
								  : 16'($urandom_range(3000, 12000)),
				      16'($urandom_range(0, 800)),
				      16'($urandom_range(0, 600)),
				      16'($urandom), 16'($urandom));
			push_walk(110);
			drain();
		end

		$display("%0d items in, %0d results checked, %0d steps detected",
			 items_sent, results_seen, steps_seen);
		$display("%0d register settings incl. extremes, wrap of time and long back-pressure",
			 settings_used);
		if (mismatches == 0 && exp_results.size() == 0) begin
			$display("pedometer_peak_step_detector_core: match");
		end else begin
			$display("pedometer_peak_step_detector_core: mismatch");
		end
		$finish;
	end

endmodule
